@@ rtl/core/pcocs_pkg.sv @@
// Shared types, constants and the control store for the phase current calibrate/scale block.
`timescale 1ns / 1ps
`default_nettype none

package pcocs_pkg;

   localparam int ADC_BITS    = 12;
   localparam int NPH         = 3;
   localparam int PHASE_W     = 2;
   localparam int SUM_W       = ADC_BITS + 16;
   localparam int CNT_W       = 16;
   localparam int SCALE_W     = 32;
   localparam int CUR_W       = 32;
   localparam int PROD_W      = ADC_BITS + SCALE_W;
   localparam int STEP_W      = 5;
   localparam int DIV_CNT_W   = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CNT_W-1:0]       CAL_COUNT_RESET = CNT_W'(256);
   localparam logic [CNT_W-1:0]       CAL_COUNT_ZERO  = CNT_W'(256);
   localparam logic [SCALE_W-1:0]     SCALE_RESET     = '0;
   localparam logic [ADC_BITS-1:0]    OFFSET_RESET    = ADC_BITS'(1 << (ADC_BITS - 1));
   localparam logic [ADC_BITS-1:0]    ADC_MAX         = '1;

   localparam logic [CSR_INDEX_W-1:0] REG_CAL_COUNT      = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_AMPS_PER_COUNT = CSR_INDEX_W'(1);

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_EMIT = 5'd0;
   localparam step_type STEP_IDLE = 5'd1;
   localparam step_type STEP_CAL  = 5'd12;
   localparam step_type STEP_DIVA = 5'd15;
   localparam step_type STEP_DIVB = 5'd18;
   localparam step_type STEP_DIVC = 5'd21;

   localparam logic [PHASE_W-1:0] PH_A = 2'd0;
   localparam logic [PHASE_W-1:0] PH_B = 2'd1;
   localparam logic [PHASE_W-1:0] PH_C = 2'd2;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_EMIT,
      OP_IDLE,
      OP_MEAS_LOAD,
      OP_MEAS_MUL,
      OP_MEAS_ROUND,
      OP_CAL_ACC,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_DIV_STORE,
      OP_CAL_CLEAR
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_INPUT,
      COND_CAL_ITEM,
      COND_BELOW_COUNT,
      COND_DIV_BUSY,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type               op;
      logic [PHASE_W-1:0]   phase;
      cond_type             cond;
      step_type             target;
   } ucode_type;

   typedef struct packed {
      logic cal_item;
      logic below_count;
      logic div_busy;
   } dp_flags_type;

   typedef struct packed {
      logic in_valid;
      logic cal_item;
      logic below_count;
      logic div_busy;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic                func;
      logic [ADC_BITS-1:0] raw_a;
      logic [ADC_BITS-1:0] raw_b;
      logic [ADC_BITS-1:0] raw_c;
   } req_word_type;

   typedef struct packed {
      logic signed [CUR_W-1:0] current_a;
      logic signed [CUR_W-1:0] current_b;
      logic signed [CUR_W-1:0] current_c;
      logic [ADC_BITS-1:0]     offset_a;
      logic [ADC_BITS-1:0]     offset_b;
      logic [ADC_BITS-1:0]     offset_c;
      logic                    calibration_done;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_word_type;

   function automatic ucode_type uword(op_type op, logic [PHASE_W-1:0] ph, cond_type c,
                                       step_type t);
      ucode_type w;
      w.op     = op;
      w.phase  = ph;
      w.cond   = c;
      w.target = t;
      return w;
   endfunction

   // The control store: one control word per step, a jump is taken when its condition holds.
   function automatic ucode_type ucode_rom(step_type step);
      ucode_type w;
      unique case (step)
         5'd0:    w = uword(OP_EMIT,       PH_A, COND_OUT_BUSY,    STEP_EMIT);
         5'd1:    w = uword(OP_IDLE,       PH_A, COND_NO_INPUT,    STEP_IDLE);
         5'd2:    w = uword(OP_NOP,        PH_A, COND_CAL_ITEM,    STEP_CAL);
         5'd3:    w = uword(OP_MEAS_LOAD,  PH_A, COND_NEVER,       STEP_EMIT);
         5'd4:    w = uword(OP_MEAS_MUL,   PH_A, COND_NEVER,       STEP_EMIT);
         5'd5:    w = uword(OP_MEAS_ROUND, PH_A, COND_NEVER,       STEP_EMIT);
         5'd6:    w = uword(OP_MEAS_LOAD,  PH_B, COND_NEVER,       STEP_EMIT);
         5'd7:    w = uword(OP_MEAS_MUL,   PH_B, COND_NEVER,       STEP_EMIT);
         5'd8:    w = uword(OP_MEAS_ROUND, PH_B, COND_NEVER,       STEP_EMIT);
         5'd9:    w = uword(OP_MEAS_LOAD,  PH_C, COND_NEVER,       STEP_EMIT);
         5'd10:   w = uword(OP_MEAS_MUL,   PH_C, COND_NEVER,       STEP_EMIT);
         5'd11:   w = uword(OP_MEAS_ROUND, PH_C, COND_ALWAYS,      STEP_EMIT);
         5'd12:   w = uword(OP_CAL_ACC,    PH_A, COND_NEVER,       STEP_EMIT);
         5'd13:   w = uword(OP_NOP,        PH_A, COND_BELOW_COUNT, STEP_EMIT);
         5'd14:   w = uword(OP_DIV_LOAD,   PH_A, COND_NEVER,       STEP_EMIT);
         5'd15:   w = uword(OP_DIV_STEP,   PH_A, COND_DIV_BUSY,    STEP_DIVA);
         5'd16:   w = uword(OP_DIV_STORE,  PH_A, COND_NEVER,       STEP_EMIT);
         5'd17:   w = uword(OP_DIV_LOAD,   PH_B, COND_NEVER,       STEP_EMIT);
         5'd18:   w = uword(OP_DIV_STEP,   PH_B, COND_DIV_BUSY,    STEP_DIVB);
         5'd19:   w = uword(OP_DIV_STORE,  PH_B, COND_NEVER,       STEP_EMIT);
         5'd20:   w = uword(OP_DIV_LOAD,   PH_C, COND_NEVER,       STEP_EMIT);
         5'd21:   w = uword(OP_DIV_STEP,   PH_C, COND_DIV_BUSY,    STEP_DIVC);
         5'd22:   w = uword(OP_DIV_STORE,  PH_C, COND_NEVER,       STEP_EMIT);
         5'd23:   w = uword(OP_CAL_CLEAR,  PH_A, COND_ALWAYS,      STEP_EMIT);
         default: w = uword(OP_NOP,        PH_A, COND_ALWAYS,      STEP_IDLE);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/pcocs_channels.sv @@
// Valid/ready channel interfaces for the sample, result and register write words.
`timescale 1ns / 1ps
`default_nettype none

interface pcocs_req_if import pcocs_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface pcocs_rsp_if import pcocs_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface pcocs_csr_if import pcocs_pkg::*; ();
   logic         valid;
   logic         ready;
   csr_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pcocs_sequencer.sv @@
// Step counter and jump logic that walks the control store.
`timescale 1ns / 1ps
`default_nettype none

module pcocs_sequencer import pcocs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ucode_type  ctrl
);

   step_type pc_ff;
   step_type pc_in;
   logic     jump;

   assign ctrl = ucode_rom(pc_ff);

   always_comb begin
      unique case (ctrl.cond)
         COND_NEVER:       jump = 1'b0;
         COND_ALWAYS:      jump = 1'b1;
         COND_NO_INPUT:    jump = !status.in_valid;
         COND_CAL_ITEM:    jump = status.cal_item;
         COND_BELOW_COUNT: jump = status.below_count;
         COND_DIV_BUSY:    jump = status.div_busy;
         COND_OUT_BUSY:    jump = status.out_busy;
         default:          jump = 1'b1;
      endcase
      pc_in = jump ? ctrl.target : pc_ff + step_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/pcocs_datapath.sv @@
// Sums, offsets, shared multiplier, rounding and the bit-serial divider.
`timescale 1ns / 1ps
`default_nettype none

module pcocs_datapath import pcocs_pkg::*; #(
   parameter int PHASE_COUNT = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  ucode_type          ctrl,
   input  logic               req_valid,
   input  req_word_type       req_word,
   input  logic [CNT_W-1:0]   cal_count,
   input  logic [SCALE_W-1:0] amps_per_count,
   output dp_flags_type       flags,
   output rsp_word_type       result
);

   localparam int RND_W = PROD_W + 1 - 8;
   localparam logic [RND_W-1:0] NEG_LIMIT = RND_W'(64'h8000_0000);
   localparam logic [RND_W-1:0] POS_LIMIT = RND_W'(64'h7FFF_FFFF);

   logic                func_ff;
   logic [ADC_BITS-1:0] raw_ff [NPH];
   logic [SUM_W-1:0]    sum_ff [NPH];
   logic [ADC_BITS-1:0] off_ff [NPH];
   logic [CUR_W-1:0]    cur_ff [NPH];
   logic [CNT_W-1:0]    samples_ff;
   logic                done_ff;
   logic [ADC_BITS-1:0] mag_ff;
   logic                neg_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [CNT_W-1:0]    rem_ff;
   logic [SUM_W-1:0]    dq_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;

   logic [CNT_W-1:0]    cnt_eff;
   logic                active;
   logic [ADC_BITS-1:0] raw_sel;
   logic [ADC_BITS-1:0] off_sel;
   logic                neg_in;
   logic [ADC_BITS-1:0] mag_in;
   logic [PROD_W:0]     rnd_sum;
   logic [RND_W-1:0]    rnd_q;
   logic [CUR_W-1:0]    cur_in;
   logic [CNT_W:0]      rem_sh;
   logic [CNT_W:0]      rem_sub;
   logic                ge;
   logic [ADC_BITS-1:0] avg_sat;
   logic                accept;

   assign accept  = (ctrl.op == OP_IDLE) && req_valid;
   assign cnt_eff = (cal_count == '0) ? CAL_COUNT_ZERO : cal_count;
   assign active  = (int'(ctrl.phase) < PHASE_COUNT) && (int'(ctrl.phase) < NPH);
   assign raw_sel = raw_ff[ctrl.phase];
   assign off_sel = off_ff[ctrl.phase];

   always_comb begin
      neg_in  = raw_sel < off_sel;
      mag_in  = neg_in ? (off_sel - raw_sel) : (raw_sel - off_sel);
      rnd_sum = {1'b0, prod_ff} + (PROD_W + 1)'(128);
      rnd_q   = rnd_sum[PROD_W:8];
      if (neg_ff) begin
         cur_in = (rnd_q > NEG_LIMIT) ? CUR_W'(NEG_LIMIT) : rnd_q[CUR_W-1:0];
         cur_in = CUR_W'(0) - cur_in;
      end else begin
         cur_in = (rnd_q > POS_LIMIT) ? CUR_W'(POS_LIMIT) : rnd_q[CUR_W-1:0];
      end
      rem_sh  = {rem_ff, dq_ff[SUM_W-1]};
      rem_sub = rem_sh - {1'b0, cnt_eff};
      ge      = rem_sh >= {1'b0, cnt_eff};
      avg_sat = (dq_ff > SUM_W'(ADC_MAX)) ? ADC_MAX : dq_ff[ADC_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_ff <= '0;
         for (int p = 0; p < NPH; p++) begin
            sum_ff[p] <= '0;
            off_ff[p] <= OFFSET_RESET;
         end
      end else begin
         unique case (ctrl.op)
            OP_CAL_ACC: begin
               samples_ff <= samples_ff + CNT_W'(1);
               for (int p = 0; p < NPH; p++) begin
                  if (p < PHASE_COUNT) begin
                     sum_ff[p] <= sum_ff[p] + SUM_W'(raw_ff[p]);
                  end
               end
            end
            OP_DIV_STORE: begin
               if (active) begin
                  off_ff[ctrl.phase] <= avg_sat;
               end
            end
            OP_CAL_CLEAR: begin
               samples_ff <= '0;
               for (int p = 0; p < NPH; p++) begin
                  sum_ff[p] <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (ctrl.op)
         OP_IDLE: begin
            if (accept) begin
               func_ff   <= req_word.func;
               raw_ff[0] <= req_word.raw_a;
               raw_ff[1] <= req_word.raw_b;
               raw_ff[2] <= req_word.raw_c;
               done_ff   <= 1'b0;
               for (int p = 0; p < NPH; p++) begin
                  cur_ff[p] <= '0;
               end
            end
         end
         OP_MEAS_LOAD: begin
            neg_ff <= neg_in;
            mag_ff <= mag_in;
         end
         OP_MEAS_MUL: begin
            prod_ff <= PROD_W'(mag_ff) * PROD_W'(amps_per_count);
         end
         OP_MEAS_ROUND: begin
            if (active) begin
               cur_ff[ctrl.phase] <= cur_in;
            end
         end
         OP_DIV_LOAD: begin
            dq_ff      <= sum_ff[ctrl.phase];
            rem_ff     <= '0;
            div_cnt_ff <= DIV_CNT_W'(SUM_W);
         end
         OP_DIV_STEP: begin
            rem_ff     <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            dq_ff      <= {dq_ff[SUM_W-2:0], ge};
            div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
         end
         OP_CAL_CLEAR: begin
            done_ff <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign flags.cal_item    = func_ff;
   assign flags.below_count = samples_ff < cnt_eff;
   assign flags.div_busy    = div_cnt_ff != DIV_CNT_W'(1);

   assign result.current_a        = cur_ff[0];
   assign result.current_b        = cur_ff[1];
   assign result.current_c        = cur_ff[2];
   assign result.offset_a         = off_ff[0];
   assign result.offset_b         = off_ff[1];
   assign result.offset_c         = off_ff[2];
   assign result.calibration_done = done_ff;

endmodule

`default_nettype wire

@@ rtl/core/phase_current_offset_calibrate_scale_top.sv @@
// Top level of the phase current offset calibration and scaling block.
//
// The req_chan channel takes one word of three ADC samples and a mode bit. In
// measure mode each phase has its offset removed and is scaled by
// amps_per_count into a signed Q16.16 current. In calibrate mode the samples
// are summed, and after calibration_count samples the averages become the new
// offsets. Every word accepted gives exactly one word on rsp_chan.
// The csr_chan channel writes calibration_count (index 0) and amps_per_count
// (index 1); it is always ready, and the user must see that it is written only
// while the block is idle; the block does not enforce this. A control store
// sequences one shared multiplier and one bit-serial divider. A measure word
// runs load, multiply and round for each phase in turn. A calibration word
// that does not finish the average is summed; the one that finishes it also
// runs three bit-serial divisions of the 28-bit sums by the count. Words are
// accepted only in the idle step. Reset restores calibration_count to 256,
// amps_per_count to 0, offsets to midscale and clears the sums. A result
// waits in the output register while rsp_chan stalls; the next emit step holds.
`timescale 1ns / 1ps
`default_nettype none

module phase_current_offset_calibrate_scale_top import pcocs_pkg::*; #(
   parameter int PHASE_COUNT = 3
) (
   input  logic        clock,
   input  logic        reset,
   pcocs_req_if.sink   req_chan,
   pcocs_rsp_if.source rsp_chan,
   pcocs_csr_if.sink   csr_chan
);

   logic [CNT_W-1:0]   cal_count_ff;
   logic [SCALE_W-1:0] amps_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff;
   ucode_type          ctrl;
   dp_flags_type       flags;
   status_type         status;
   rsp_word_type       result;
   logic               out_busy;
   logic               emit_load;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_count_ff <= CAL_COUNT_RESET;
         amps_ff      <= SCALE_RESET;
      end else if (csr_chan.valid) begin
         if (csr_chan.word.reg_index == REG_CAL_COUNT) begin
            cal_count_ff <= csr_chan.word.data[CNT_W-1:0];
         end
         if (csr_chan.word.reg_index == REG_AMPS_PER_COUNT) begin
            amps_ff <= csr_chan.word.data[SCALE_W-1:0];
         end
      end
   end

   assign out_busy  = rsp_valid_ff && !rsp_chan.ready;
   assign emit_load = (ctrl.op == OP_EMIT) && !out_busy;

   assign status.in_valid    = req_chan.valid;
   assign status.cal_item    = flags.cal_item;
   assign status.below_count = flags.below_count;
   assign status.div_busy    = flags.div_busy;
   assign status.out_busy    = out_busy;

   assign req_chan.ready = (ctrl.op == OP_IDLE);

   pcocs_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   pcocs_datapath #(
      .PHASE_COUNT (PHASE_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .req_valid      (req_chan.valid),
      .req_word       (req_chan.word),
      .cal_count      (cal_count_ff),
      .amps_per_count (amps_ff),
      .flags          (flags),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.word  = rsp_word_ff;

endmodule

`default_nettype wire
